@@ src/aarm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Axis-angle rotation matrix package
// Shared widths, CORDIC constants and the arctangent table.
// ----------------------------------------------------------------------------
package aarm_pkg;

    localparam int ATAN_LEN = 24;
    localparam int CW       = 36;   // CORDIC datapath width, Q30 plus headroom

    typedef logic signed [CW-1:0] cword_t;
    typedef logic signed [15:0]   q14_t;

    localparam cword_t Q30_PI      = 36'sd3373259426;
    localparam cword_t Q30_HALF_PI = 36'sd1686629713;
    localparam cword_t Q30_GAIN    = 36'sd652032874;
    localparam logic signed [17:0] Q14_ONE = 18'sd16384;

    // One request travelling along the CORDIC row.
    typedef struct packed {
        cword_t x;
        cword_t y;
        cword_t z;
        logic   flip;
        q14_t   ax;
        q14_t   ay;
        q14_t   az;
    } cordic_t;

    function automatic cword_t atan_q30(input int i);
        cword_t r;
        r = '0;
        unique case (i)
            0:  r = 36'sh03243F6A8;
            1:  r = 36'sh01DAC6705;
            2:  r = 36'sh00FADBAFC;
            3:  r = 36'sh007F56EA6;
            4:  r = 36'sh003FEAB76;
            5:  r = 36'sh001FFD55B;
            6:  r = 36'sh000FFFAAA;
            7:  r = 36'sh0007FFF55;
            8:  r = 36'sh0003FFFEA;
            9:  r = 36'sh0001FFFFD;
            10: r = 36'sh0000FFFFF;
            11: r = 36'sh00007FFFF;
            12: r = 36'sh00003FFFF;
            13: r = 36'sh00001FFFF;
            14: r = 36'sh00000FFFF;
            15: r = 36'sh000007FFF;
            16: r = 36'sh000003FFF;
            17: r = 36'sh000001FFF;
            18: r = 36'sh000000FFF;
            19: r = 36'sh0000007FF;
            20: r = 36'sh0000003FF;
            21: r = 36'sh0000001FF;
            22: r = 36'sh0000000FF;
            23: r = 36'sh00000007F;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

@@ src/axis_angle_rotation_matrix.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Axis-angle rotation matrix
// Streams 3x3 rotation matrices from an angle and a unit axis.
// ----------------------------------------------------------------------------
// The slave channel takes one request per beat: angle (Q3.13 radians) and
// the axis components (Q1.14), packed into s_axis_tdata from the low bits.
// The master channel returns the nine matrix entries, r00 in the low bits,
// each Q1.14 saturated to plus or minus one.
// A request passes a quadrant fold stage, a row of CORDIC_STAGES cells
// (one micro-rotation each, at most 24), three stages of rounding and
// products, and the output register: CORDIC_STAGES + 5 register stages in
// all. One request is taken every cycle while the pipeline advances.
// The whole pipeline advances whenever the output register is empty or is
// being read; when the receiver stalls with a full output register the
// pipeline freezes and s_axis_tready drops in the same cycle.
// Synchronous active-low reset empties every stage; no request is in
// flight afterwards. The outputs carry no state between requests.
// ----------------------------------------------------------------------------
module axis_angle_rotation_matrix
    import aarm_pkg::*;
#(
    parameter int CORDIC_STAGES = 14
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // angle[15:0], axis_x[31:16], axis_y[47:32], axis_z[63:48]
    input  logic [63:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // r00[15:0], r01, r02, r10, r11, r12, r20, r21, r22[143:128]
    output logic [143:0] m_axis_tdata
);

    localparam int NST = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;

    logic en;
    logic out_vld_reg;
    logic [143:0] out_dat_reg;

    // The pipeline moves when the output register can take a new value.
    assign en            = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = en;

    // Fold stage: widen angle to Q30 and bring it into -pi/2..pi/2.
    logic    fold_vld_reg;
    cordic_t fold_reg, fold_next;
    cword_t  z_in;

    always_comb begin
        z_in = cword_t'($signed(s_axis_tdata[15:0])) <<< 17;
        fold_next.x    = Q30_GAIN;
        fold_next.y    = '0;
        fold_next.ax   = s_axis_tdata[31:16];
        fold_next.ay   = s_axis_tdata[47:32];
        fold_next.az   = s_axis_tdata[63:48];
        fold_next.flip = 1'b0;
        fold_next.z    = z_in;
        if (z_in > Q30_HALF_PI) begin
            fold_next.z    = z_in - Q30_PI;
            fold_next.flip = 1'b1;
        end else if (z_in < -Q30_HALF_PI) begin
            fold_next.z    = z_in + Q30_PI;
            fold_next.flip = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fold_vld_reg <= 1'b0;
        end else if (en) begin
            fold_vld_reg <= s_axis_tvalid;
        end
        if (en) begin
            fold_reg <= fold_next;
        end
    end

    // Row of CORDIC cells.
    logic    vld_chain [NST+1];
    cordic_t dat_chain [NST+1];

    assign vld_chain[0] = fold_vld_reg;
    assign dat_chain[0] = fold_reg;

    for (genvar g = 0; g < NST; g++) begin : g_cell
        aarm_cordic_cell #(.STAGE(g)) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .vld_in  (vld_chain[g]),
            .dat_in  (dat_chain[g]),
            .vld_out (vld_chain[g+1]),
            .dat_out (dat_chain[g+1])
        );
    end

    logic         mat_vld;
    logic [143:0] mat_dat;

    aarm_matrix u_matrix (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .vld_in  (vld_chain[NST]),
        .dat_in  (dat_chain[NST]),
        .vld_out (mat_vld),
        .mat_out (mat_dat)
    );

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (en) begin
            out_vld_reg <= mat_vld;
        end
        if (en) begin
            out_dat_reg <= mat_dat;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_dat_reg;

endmodule

@@ src/aarm_cordic_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CORDIC cell
// One rotation-mode micro-rotation with a fixed shift, registered.
// ----------------------------------------------------------------------------
module aarm_cordic_cell
    import aarm_pkg::*;
#(
    parameter int STAGE = 0
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    en,
    input  logic    vld_in,
    input  cordic_t dat_in,
    output logic    vld_out,
    output cordic_t dat_out
);

    logic    vld_reg;
    cordic_t dat_reg, dat_next;

    always_comb begin
        dat_next = dat_in;
        if (!dat_in.z[CW-1]) begin
            dat_next.x = dat_in.x - (dat_in.y >>> STAGE);
            dat_next.y = dat_in.y + (dat_in.x >>> STAGE);
            dat_next.z = dat_in.z - atan_q30(STAGE);
        end else begin
            dat_next.x = dat_in.x + (dat_in.y >>> STAGE);
            dat_next.y = dat_in.y - (dat_in.x >>> STAGE);
            dat_next.z = dat_in.z + atan_q30(STAGE);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= vld_in;
        end
        if (en) begin
            dat_reg <= dat_next;
        end
    end

    assign vld_out = vld_reg;
    assign dat_out = dat_reg;

endmodule

@@ src/aarm_matrix.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rodrigues matrix builder
// Rounds sin and cos, then forms the nine entries over three stages.
// ----------------------------------------------------------------------------
module aarm_matrix
    import aarm_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    en,
    input  logic    vld_in,
    input  cordic_t dat_in,
    output logic    vld_out,
    output logic [143:0] mat_out
);

    function automatic logic signed [17:0] rnd_q14(input cword_t v);
        cword_t t;
        t = (v + 36'sd32768) >>> 16;
        if (t > 36'sd16384)       return Q14_ONE;
        else if (t < -36'sd16384) return -Q14_ONE;
        else                      return t[17:0];
    endfunction

    function automatic q14_t sat_q42(input logic signed [47:0] v);
        logic signed [47:0] t;
        t = (v + 48'sd134217728) >>> 28;
        if (t > 48'sd16384)       return 16'sd16384;
        else if (t < -48'sd16384) return -16'sd16384;
        else                      return t[15:0];
    endfunction

    // Stage A: rounded sin/cos, axis.
    logic [2:0] vld_reg;
    logic signed [17:0] s_reg, c_reg, omc_reg;
    q14_t l_reg, m_reg, n_reg;
    // Stage B: pair products and sine products.
    logic signed [31:0] ll_reg, mm_reg, nn_reg, lm_reg, ln_reg, mn_reg;
    logic signed [33:0] ls_reg, ms_reg, ns_reg;
    logic signed [17:0] c2_reg, omc2_reg;
    // Stage C: results.
    q14_t r_reg [9];

    logic signed [17:0] c_next, s_next;
    always_comb begin
        c_next = rnd_q14(dat_in.flip ? -dat_in.x : dat_in.x);
        s_next = rnd_q14(dat_in.flip ? -dat_in.y : dat_in.y);
    end

    logic signed [47:0] t_ll, t_mm, t_nn, t_lm, t_ln, t_mn, ct, lst, mst, nst;
    always_comb begin
        t_ll = 48'(ll_reg) * 48'(omc2_reg);
        t_mm = 48'(mm_reg) * 48'(omc2_reg);
        t_nn = 48'(nn_reg) * 48'(omc2_reg);
        t_lm = 48'(lm_reg) * 48'(omc2_reg);
        t_ln = 48'(ln_reg) * 48'(omc2_reg);
        t_mn = 48'(mn_reg) * 48'(omc2_reg);
        ct   = 48'(c2_reg) <<< 28;
        lst  = 48'(ls_reg) <<< 14;
        mst  = 48'(ms_reg) <<< 14;
        nst  = 48'(ns_reg) <<< 14;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[1:0], vld_in};
        end
        if (en) begin
            c_reg   <= c_next;
            s_reg   <= s_next;
            omc_reg <= Q14_ONE - c_next;
            l_reg   <= dat_in.ax;
            m_reg   <= dat_in.ay;
            n_reg   <= dat_in.az;

            ll_reg   <= 32'(l_reg) * 32'(l_reg);
            mm_reg   <= 32'(m_reg) * 32'(m_reg);
            nn_reg   <= 32'(n_reg) * 32'(n_reg);
            lm_reg   <= 32'(l_reg) * 32'(m_reg);
            ln_reg   <= 32'(l_reg) * 32'(n_reg);
            mn_reg   <= 32'(m_reg) * 32'(n_reg);
            ls_reg   <= 34'(l_reg) * 34'(s_reg);
            ms_reg   <= 34'(m_reg) * 34'(s_reg);
            ns_reg   <= 34'(n_reg) * 34'(s_reg);
            c2_reg   <= c_reg;
            omc2_reg <= omc_reg;

            r_reg[0] <= sat_q42(t_ll + ct);
            r_reg[1] <= sat_q42(t_lm - nst);
            r_reg[2] <= sat_q42(t_ln + mst);
            r_reg[3] <= sat_q42(t_lm + nst);
            r_reg[4] <= sat_q42(t_mm + ct);
            r_reg[5] <= sat_q42(t_mn - lst);
            r_reg[6] <= sat_q42(t_ln - mst);
            r_reg[7] <= sat_q42(t_mn + lst);
            r_reg[8] <= sat_q42(t_nn + ct);
        end
    end

    assign vld_out = vld_reg[2];
    assign mat_out = {r_reg[8], r_reg[7], r_reg[6], r_reg[5], r_reg[4],
                      r_reg[3], r_reg[2], r_reg[1], r_reg[0]};

endmodule

@@ src/aarm_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Axis-angle rotation matrix checker
// Port-level properties of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module aarm_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [143:0] m_axis_tdata
);

    // A stalled result holds its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // Ready drops only while a result waits.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output backpressure");

    // The first entry, r00, stays within plus or minus one.
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> ($signed(m_axis_tdata[15:0]) <= 16'sd16384) &&
                          ($signed(m_axis_tdata[15:0]) >= -16'sd16384))
        else $error("r00 out of range");

    // Nothing emerges right after reset.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind axis_angle_rotation_matrix aarm_checker u_aarm_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
